// File: sv/pil_pkg.sv
package pil_pkg;

    // table and number format
    localparam int MAX_POINTS   = 64;
    localparam int NUMBER_WIDTH = 32;
    localparam int FRAC_W       = 16;
    localparam int INDEX_W      = 6;
    localparam int COUNT_W      = 7;
    localparam int TOL_W        = NUMBER_WIDTH - 1;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int DIFF_W       = NUMBER_WIDTH + 1;
    localparam int QUOT_W       = FRAC_W + 1;
    localparam int PROD_W       = QUOT_W + 1 + DIFF_W;
    localparam int DIV_CNT_W    = $clog2(QUOT_W);

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // input op codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERFACE_POSITION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE      = 2'd2;

    // classified item, as queued for the back end
    typedef struct packed {
        logic                           is_query;
        logic [ADDR_W-1:0]              index;   // load slot, or last breakpoint for a query
        logic signed [NUMBER_WIDTH-1:0] data_a;  // position for a load, y for a query
        logic signed [NUMBER_WIDTH-1:0] data_b;  // value for a load
        logic                           off;
        logic                           empty;
    } q_entry_t;

    typedef struct packed {
        logic                    start;
        logic [NUMBER_WIDTH-1:0] num;
        logic [NUMBER_WIDTH-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FIRST,
        BK_LAST,
        BK_SCAN,
        BK_DIV,
        BK_ADD,
        BK_EMIT
    } back_state_t;

endpackage

// File: sv/pil_front.sv
module pil_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    op,
    input  logic [pil_pkg::INDEX_W-1:0]             entry_index,
    input  logic signed [pil_pkg::NUMBER_WIDTH-1:0] entry_position,
    input  logic signed [pil_pkg::NUMBER_WIDTH-1:0] entry_value,
    input  logic signed [pil_pkg::NUMBER_WIDTH-1:0] query_x,
    input  logic signed [pil_pkg::NUMBER_WIDTH-1:0] query_y,
    input  logic signed [pil_pkg::NUMBER_WIDTH-1:0] interface_position,
    input  logic [pil_pkg::TOL_W-1:0]               position_tolerance,
    input  logic [pil_pkg::COUNT_W-1:0]             points_in_use,
    output logic                                    q_valid,
    output pil_pkg::q_entry_t                       q_entry,
    input  logic                                    q_pop
);
    import pil_pkg::*;

    q_entry_t             slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;

    logic signed [DIFF_W-1:0] x_delta;
    logic [DIFF_W-1:0]        x_dist;
    logic [COUNT_W-1:0]       n_pts;
    logic                     load_ok;
    logic                     push;
    q_entry_t                 new_entry;

    // classify the incoming beat
    always_comb
    begin
        x_delta = DIFF_W'(query_x) - DIFF_W'(interface_position);
        x_dist  = x_delta[DIFF_W-1] ? DIFF_W'(-x_delta) : DIFF_W'(x_delta);
        n_pts   = (32'(points_in_use) > MAX_POINTS) ? COUNT_W'(MAX_POINTS) : points_in_use;
        load_ok = 32'(entry_index) < MAX_POINTS;

        new_entry.is_query = (op == OP_QUERY);
        new_entry.off      = x_dist > DIFF_W'(position_tolerance);
        new_entry.empty    = (n_pts == '0);
        new_entry.data_b   = entry_value;
        if (op == OP_QUERY)
        begin
            new_entry.index  = ADDR_W'(n_pts - 1'b1);
            new_entry.data_a = query_y;
        end
        else
        begin
            new_entry.index  = ADDR_W'(entry_index);
            new_entry.data_a = entry_position;
        end
    end

    assign in_ready = (count_reg != QCNT_W'(Q_DEPTH));
    // out-of-range loads are taken and dropped
    assign push     = in_valid && in_ready && ((op == OP_QUERY) || load_ok);
    assign q_valid  = (count_reg != '0);
    assign q_entry  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

// File: sv/pil_div.sv
module pil_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pil_pkg::div_req_t req,
    output pil_pkg::div_rsp_t rsp
);
    import pil_pkg::*;

    // restoring division of num * 2^FRAC_W by den, with num <= den
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIFF_W-1:0]       rem_reg, rem_next;
    logic [NUMBER_WIDTH-1:0] den_reg, den_next;
    logic [QUOT_W-1:0]       quot_reg, quot_next;

    logic [DIFF_W-1:0] rem_sh;
    logic              ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        // first step takes the integer bit, the rest shift in fraction bits
        rem_sh    = (cnt_reg == '0) ? rem_reg : {rem_reg[DIFF_W-2:0], 1'b0};
        ge        = rem_sh >= DIFF_W'(den_reg);

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = DIFF_W'(req.num);
            den_next  = req.den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sh - DIFF_W'(den_reg) : rem_sh;
            quot_next = {quot_reg[QUOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// File: sv/pil_back.sv
module pil_back (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     q_valid,
    input  pil_pkg::q_entry_t                        q_entry,
    output logic                                     q_pop,
    output pil_pkg::div_req_t                        div_req,
    input  pil_pkg::div_rsp_t                        div_rsp,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [pil_pkg::NUMBER_WIDTH-1:0]  interpolated_value,
    output logic                                     off_interface,
    output logic                                     table_empty
);
    import pil_pkg::*;

    // breakpoint tables
    logic signed [NUMBER_WIDTH-1:0] pos_mem [MAX_POINTS];
    logic signed [NUMBER_WIDTH-1:0] val_mem [MAX_POINTS];
    logic signed [NUMBER_WIDTH-1:0] rd_pos, rd_val;
    logic [ADDR_W-1:0]              rd_addr;
    logic                           mem_we;

    back_state_t state_reg, state_next;

    logic signed [NUMBER_WIDTH-1:0] y_reg, y_next;
    logic [ADDR_W-1:0]              last_reg, last_next;
    logic [ADDR_W-1:0]              idx_reg, idx_next;
    logic signed [NUMBER_WIDTH-1:0] prev_pos_reg, prev_pos_next;
    logic signed [NUMBER_WIDTH-1:0] prev_val_reg, prev_val_next;
    logic signed [NUMBER_WIDTH-1:0] last_val_reg, last_val_next;
    logic signed [DIFF_W-1:0]       diff_reg, diff_next;
    logic signed [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [NUMBER_WIDTH-1:0] res_reg, res_next;
    logic                           off_reg, off_next;
    logic                           empty_reg, empty_next;

    logic                           out_valid_reg, out_valid_next;
    logic signed [NUMBER_WIDTH-1:0] out_value_reg;
    logic                           out_off_reg, out_empty_reg;
    logic                           out_load;

    logic signed [DIFF_W-1:0] den;
    logic signed [DIFF_W-1:0] num;

    always_comb
    begin
        state_next    = state_reg;
        y_next        = y_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        prev_pos_next = prev_pos_reg;
        prev_val_next = prev_val_reg;
        last_val_next = last_val_reg;
        diff_next     = diff_reg;
        prod_next     = prod_reg;
        res_next      = res_reg;
        off_next      = off_reg;
        empty_next    = empty_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        rd_addr       = '0;
        out_load      = 1'b0;
        div_req       = '0;
        den           = DIFF_W'(rd_pos) - DIFF_W'(prev_pos_reg);
        num           = DIFF_W'(y_reg) - DIFF_W'(prev_pos_reg);

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (!q_entry.is_query)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        y_next     = q_entry.data_a;
                        last_next  = q_entry.index;
                        off_next   = q_entry.off;
                        empty_next = q_entry.empty;
                        if (q_entry.off || q_entry.empty)
                        begin
                            res_next   = '0;
                            state_next = BK_EMIT;
                        end
                        else
                        begin
                            rd_addr    = '0;
                            state_next = BK_FIRST;
                        end
                    end
                end
            end

            // at or below the first breakpoint: clamp
            BK_FIRST:
            begin
                prev_pos_next = rd_pos;
                prev_val_next = rd_val;
                if (y_reg <= rd_pos)
                begin
                    res_next   = rd_val;
                    state_next = BK_EMIT;
                end
                else
                begin
                    rd_addr    = last_reg;
                    state_next = BK_LAST;
                end
            end

            // at or above the last breakpoint: clamp
            BK_LAST:
            begin
                if (y_reg >= rd_pos)
                begin
                    res_next   = rd_val;
                    state_next = BK_EMIT;
                end
                else
                begin
                    last_val_next = rd_val;
                    idx_next      = ADDR_W'(1);
                    rd_addr       = ADDR_W'(1);
                    state_next    = BK_SCAN;
                end
            end

            // segment search, one breakpoint per cycle
            BK_SCAN:
            begin
                if ((prev_pos_reg <= y_reg) && (y_reg <= rd_pos))
                begin
                    if (den <= 0)
                    begin
                        res_next   = prev_val_reg;
                        state_next = BK_EMIT;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = num[NUMBER_WIDTH-1:0];
                        div_req.den   = den[NUMBER_WIDTH-1:0];
                        diff_next     = DIFF_W'(rd_val) - DIFF_W'(prev_val_reg);
                        state_next    = BK_DIV;
                    end
                end
                else if (idx_reg == last_reg)
                begin
                    // unsorted table, no segment holds y
                    res_next   = last_val_reg;
                    state_next = BK_EMIT;
                end
                else
                begin
                    prev_pos_next = rd_pos;
                    prev_val_next = rd_val;
                    idx_next      = idx_reg + 1'b1;
                    rd_addr       = idx_reg + 1'b1;
                end
            end

            BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    prod_next  = $signed({1'b0, div_rsp.quot}) * diff_reg;
                    state_next = BK_ADD;
                end
            end

            BK_ADD:
            begin
                // arithmetic shift gives the floor of t * diff / 2^16
                res_next   = prev_val_reg + NUMBER_WIDTH'(prod_reg >>> FRAC_W);
                state_next = BK_EMIT;
            end

            BK_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !out_ready) || out_load;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[q_entry.index] <= q_entry.data_a;
            val_mem[q_entry.index] <= q_entry.data_b;
        end
        rd_pos <= pos_mem[rd_addr];
        rd_val <= val_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg        <= y_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        prev_pos_reg <= prev_pos_next;
        prev_val_reg <= prev_val_next;
        last_val_reg <= last_val_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        off_reg      <= off_next;
        empty_reg    <= empty_next;
        if (out_load)
        begin
            out_value_reg <= res_reg;
            out_off_reg   <= off_reg;
            out_empty_reg <= empty_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign interpolated_value = out_value_reg;
    assign off_interface      = out_off_reg;
    assign table_empty        = out_empty_reg;

endmodule

// File: sv/piecewise_linear_interpolator_top.sv
// Piecewise linear interpolator over a table of up to 64 breakpoints in Q15.16.
// A load beat (op 0) writes one table slot and yields no result; a query beat
// (op 1) yields exactly one result beat. The front end classifies each beat on
// entry (distance of query_x from the interface, empty table) and queues it in
// a two-deep queue, so input beats keep flowing while the back end works and
// while a result waits on out_ready, until the queue is full. The back end
// executes queue entries in order. A query that is off the interface or meets
// an empty table goes straight to the emit state. Otherwise the back end
// reads the first and last breakpoints (clamp cases), then walks the table one
// breakpoint per cycle through its single read port, and for a segment of
// nonzero length runs a 17-step restoring divider for the 16-bit fraction,
// one multiply and one add. The breakpoint tables have no reset; querying a
// slot that was never loaded gives an undefined value. Write config registers
// only while the block is idle.
module piecewise_linear_interpolator_top (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // config write port
    input  logic                                     cfg_we,
    input  logic [pil_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [pil_pkg::NUMBER_WIDTH-1:0]         cfg_data,
    // input beat
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     op,
    input  logic [pil_pkg::INDEX_W-1:0]              entry_index,
    input  logic signed [pil_pkg::NUMBER_WIDTH-1:0]  entry_position,
    input  logic signed [pil_pkg::NUMBER_WIDTH-1:0]  entry_value,
    input  logic signed [pil_pkg::NUMBER_WIDTH-1:0]  query_x,
    input  logic signed [pil_pkg::NUMBER_WIDTH-1:0]  query_y,
    // result beat
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [pil_pkg::NUMBER_WIDTH-1:0]  interpolated_value,
    output logic                                     off_interface,
    output logic                                     table_empty
);
    import pil_pkg::*;

    // config registers
    logic signed [NUMBER_WIDTH-1:0] interface_position_reg, interface_position_next;
    logic [TOL_W-1:0]               position_tolerance_reg, position_tolerance_next;
    logic [COUNT_W-1:0]             points_in_use_reg, points_in_use_next;

    // front to back queue
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_entry;

    // back end to divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    // register writes; unknown indexes are ignored
    always_comb
    begin
        interface_position_next = interface_position_reg;
        position_tolerance_next = position_tolerance_reg;
        points_in_use_next      = points_in_use_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_INTERFACE_POSITION: interface_position_next = $signed(cfg_data);
                REG_POSITION_TOLERANCE: position_tolerance_next = cfg_data[TOL_W-1:0];
                REG_POINTS_IN_USE:      points_in_use_next      = cfg_data[COUNT_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interface_position_reg <= '0;
            position_tolerance_reg <= '0;
            points_in_use_reg      <= '0;
        end
        else
        begin
            interface_position_reg <= interface_position_next;
            position_tolerance_reg <= position_tolerance_next;
            points_in_use_reg      <= points_in_use_next;
        end
    end

    // accept and classify
    pil_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .op                 (op),
        .entry_index        (entry_index),
        .entry_position     (entry_position),
        .entry_value        (entry_value),
        .query_x            (query_x),
        .query_y            (query_y),
        .interface_position (interface_position_reg),
        .position_tolerance (position_tolerance_reg),
        .points_in_use      (points_in_use_reg),
        .q_valid            (q_valid),
        .q_entry            (q_entry),
        .q_pop              (q_pop)
    );

    // fraction divider shared by all queries
    pil_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // table, segment search and interpolation
    pil_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_valid            (q_valid),
        .q_entry            (q_entry),
        .q_pop              (q_pop),
        .div_req            (div_req),
        .div_rsp            (div_rsp),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .interpolated_value (interpolated_value),
        .off_interface      (off_interface),
        .table_empty        (table_empty)
    );

    // a flagged result always carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (off_interface || table_empty) |-> interpolated_value == '0)
        else $error("flagged result with nonzero value");

    // the back end only pops an occupied queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // back pressure on the input only when the queue holds work
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_valid)
        else $error("input stalled with empty queue");

endmodule
